// File: rtl/core/music_text_preprocessor_macros.svh
// -----------------------------------------------------------------------------
// Music text preprocessor assertion macros
// Shared concurrent assertion forms, clocked on i_clk, disabled in reset.
// -----------------------------------------------------------------------------
`ifndef MUSIC_TEXT_PREPROCESSOR_MACROS_SVH
`define MUSIC_TEXT_PREPROCESSOR_MACROS_SVH

// same-cycle implication
`define MTP_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MTP_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/mtp_pkg.sv
// -----------------------------------------------------------------------------
// Music text preprocessor package
// Result word types, codes, character constants and queue sizing.
// -----------------------------------------------------------------------------
package mtp_pkg;

    localparam int unsigned     MTP_NEST_MAX = 255;
    localparam longint unsigned MTP_LINE_MAX = 64'd16777215;

    localparam int MTP_CHAR_W = 16;
    localparam int MTP_LINE_W = 24;

    // result queue: an input word may push two results
    localparam int MTP_FIFO_DEPTH   = 3;
    localparam int MTP_PTR_W        = $clog2(MTP_FIFO_DEPTH);
    localparam int MTP_LVL_W        = $clog2(MTP_FIFO_DEPTH + 1);
    localparam int MTP_ACCEPT_LEVEL = MTP_FIFO_DEPTH - 2;

    localparam logic [MTP_CHAR_W-1:0] CH_TAB   = 16'd9;
    localparam logic [MTP_CHAR_W-1:0] CH_NL    = 16'd10;
    localparam logic [MTP_CHAR_W-1:0] CH_CR    = 16'd13;
    localparam logic [MTP_CHAR_W-1:0] CH_SPACE = 16'h0020;
    localparam logic [MTP_CHAR_W-1:0] CH_LPAR  = 16'd40;
    localparam logic [MTP_CHAR_W-1:0] CH_RPAR  = 16'd41;
    localparam logic [MTP_CHAR_W-1:0] CH_STAR  = 16'd42;
    localparam logic [MTP_CHAR_W-1:0] CH_SLASH = 16'd47;
    localparam logic [MTP_CHAR_W-1:0] CH_UPR_A = 16'd65;
    localparam logic [MTP_CHAR_W-1:0] CH_UPR_Z = 16'd90;
    localparam logic [MTP_CHAR_W-1:0] CH_LBRK  = 16'd91;
    localparam logic [MTP_CHAR_W-1:0] CH_RBRK  = 16'd93;
    localparam logic [MTP_CHAR_W-1:0] CH_EM_HI = 16'd129;
    localparam logic [MTP_CHAR_W-1:0] CH_EM_LO = 16'd64;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_STRAY_CMT    = 3'd1,
        ERR_STRAY_BRK    = 3'd2,
        ERR_STRAY_PAR    = 3'd3,
        ERR_OPEN_BRK     = 3'd4,
        ERR_OPEN_PAR     = 3'd5
    } t_err;

    typedef struct packed {
        t_kind                 kind;
        logic [MTP_CHAR_W-1:0] out_char;
        logic [MTP_LINE_W-1:0] line_number;
        t_err                  error_code;
        logic                  last;
    } t_result;

    // results produced by one accepted input word
    typedef struct packed {
        logic [1:0] n;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

// File: rtl/core/mtp_ifs.sv
// -----------------------------------------------------------------------------
// Music text preprocessor stream interfaces
// Valid/ready channels for source characters and result words.
// -----------------------------------------------------------------------------
interface mtp_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] char_code;
    logic        is_end;

    modport source (output valid, output char_code, output is_end, input ready);
    modport sink   (input valid, input char_code, input is_end, output ready);
endinterface

interface mtp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] out_char;
    logic [23:0] line_number;
    logic [2:0]  error_code;
    logic        last;

    modport source (output valid, output kind, output out_char, output line_number,
                    output error_code, output last, input ready);
    modport sink   (input valid, input kind, input out_char, input line_number,
                    input error_code, input last, output ready);
endinterface

// File: rtl/core/mtp_core.sv
// -----------------------------------------------------------------------------
// Music text preprocessor core
// Per-word newline folding, comment stripping, nesting count and error logic.
// -----------------------------------------------------------------------------
module mtp_core #(
    parameter int unsigned     NEST_MAX = 255,
    parameter longint unsigned LINE_MAX = 64'd16777215
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic [15:0]              i_char_code,
    input  logic                     i_is_end,
    output mtp_pkg::t_push           o_push
);
    import mtp_pkg::*;

    localparam int NEST_W = $clog2(NEST_MAX + 1);
    localparam int LINE_W = $clog2(LINE_MAX + 1);
    localparam logic [NEST_W-1:0] NEST_TOP = NEST_W'(NEST_MAX);
    localparam logic [LINE_W-1:0] LINE_TOP = LINE_W'(LINE_MAX);

    typedef struct packed {
        logic [MTP_CHAR_W-1:0] held_char;
        logic                  held_valid;
        logic                  in_line;
        logic                  in_block;
        logic                  swallow_lf;
        logic                  swallow_cr;
        logic [NEST_W-1:0]     bracket;
        logic [NEST_W-1:0]     paren;
        logic [LINE_W-1:0]     line;
        logic                  halted;
    } t_st;

    typedef struct packed {
        t_st     st;
        t_result res;
        logic    made;
    } t_hres;

    function automatic t_st st_reset();
        t_st s;
        s      = '0;
        s.line = LINE_W'(1);
        return s;
    endfunction

    function automatic logic [MTP_LINE_W-1:0] line24(logic [LINE_W-1:0] v);
        logic [63:0] t;
        t = 64'(v);
        return t[MTP_LINE_W-1:0];
    endfunction

    function automatic t_hres fail(t_hres o, t_err code);
        t_hres r;
        r                  = o;
        r.st.halted        = 1'b1;
        r.st.held_valid    = 1'b0;
        r.res              = '0;
        r.res.kind         = KIND_ERR;
        r.res.line_number  = line24(o.st.line);
        r.res.error_code   = code;
        r.res.last         = 1'b1;
        r.made             = 1'b1;
        return r;
    endfunction

    // decide the held character, c is lookahead when nv
    function automatic t_hres handle(t_st s, logic nv, logic [MTP_CHAR_W-1:0] c);
        t_hres                 o;
        logic [MTP_CHAR_W-1:0] h;
        logic                  pair_used;
        logic                  done;
        o         = '0;
        o.st      = s;
        h         = s.held_char;
        pair_used = 1'b0;
        done      = 1'b0;
        priority if (h == CH_NL) begin
            o.st.in_line = 1'b0;
            if (s.line != LINE_TOP) begin
                o.st.line = s.line + LINE_W'(1);
            end
            o.res.kind        = KIND_CHAR;
            o.res.out_char    = CH_NL;
            o.res.line_number = line24(o.st.line);
            o.made            = 1'b1;
        end else if (nv && h == CH_SLASH && c == CH_SLASH) begin
            o.st.in_line = 1'b1;
            pair_used    = 1'b1;
        end else if (!s.in_line && nv && h == CH_STAR && c == CH_SLASH) begin
            pair_used = 1'b1;
            if (!s.in_block) begin
                o    = fail(o, ERR_STRAY_CMT);
                done = 1'b1;
            end else begin
                o.st.in_block = 1'b0;
            end
        end else if (!s.in_line && nv && h == CH_SLASH && c == CH_STAR) begin
            pair_used     = 1'b1;
            o.st.in_block = 1'b1;
        end else if (s.in_block || s.in_line) begin
            // inside a comment: dropped
        end else if (h == CH_SPACE || h == CH_TAB) begin
            // blank: dropped
        end else if (nv && h == CH_EM_HI && c == CH_EM_LO) begin
            pair_used = 1'b1;
        end else begin
            if (h == CH_LBRK && s.bracket != NEST_TOP) begin
                o.st.bracket = s.bracket + NEST_W'(1);
            end
            if (h == CH_RBRK) begin
                if (s.bracket == '0) begin
                    o    = fail(o, ERR_STRAY_BRK);
                    done = 1'b1;
                end else begin
                    o.st.bracket = s.bracket - NEST_W'(1);
                end
            end
            if (h == CH_LPAR && s.paren != NEST_TOP) begin
                o.st.paren = s.paren + NEST_W'(1);
            end
            if (h == CH_RPAR) begin
                if (s.paren == '0) begin
                    o    = fail(o, ERR_STRAY_PAR);
                    done = 1'b1;
                end else begin
                    o.st.paren = s.paren - NEST_W'(1);
                end
            end
            if (!done) begin
                if (h >= CH_UPR_A && h <= CH_UPR_Z) begin
                    h = h | CH_SPACE;
                end
                o.res.kind     = KIND_CHAR;
                o.res.out_char = h;
                o.made         = 1'b1;
            end
        end
        if (!done) begin
            if (nv && !pair_used) begin
                o.st.held_char  = c;
                o.st.held_valid = 1'b1;
            end else begin
                o.st.held_valid = 1'b0;
            end
        end
        return o;
    endfunction

    t_st                   r_st;
    t_st                   n_st;
    t_st                   w_st2;
    t_hres                 w_hr;
    t_result               w_fin;
    logic [MTP_CHAR_W-1:0] w_c;
    t_push                 w_push;

    always_comb begin
        n_st   = r_st;
        w_push = '0;
        w_st2  = r_st;
        w_hr   = '0;
        w_fin  = '0;
        w_c    = i_char_code;
        if (i_accept) begin
            if (i_is_end) begin
                n_st = st_reset();
                if (!r_st.halted) begin
                    if (r_st.held_valid) begin
                        w_hr  = handle(r_st, 1'b0, '0);
                        w_st2 = w_hr.st;
                        if (w_hr.made) begin
                            w_push.r0 = w_hr.res;
                            w_push.n  = 2'd1;
                        end
                    end
                    if (!w_st2.halted) begin
                        w_fin.last = 1'b1;
                        if (w_st2.bracket != '0) begin
                            w_fin.kind        = KIND_ERR;
                            w_fin.error_code  = ERR_OPEN_BRK;
                            w_fin.line_number = line24(w_st2.line);
                        end else if (w_st2.paren != '0) begin
                            w_fin.kind        = KIND_ERR;
                            w_fin.error_code  = ERR_OPEN_PAR;
                            w_fin.line_number = line24(w_st2.line);
                        end else begin
                            w_fin.kind = KIND_END;
                        end
                        if (w_push.n == 2'd0) begin
                            w_push.r0 = w_fin;
                        end else begin
                            w_push.r1 = w_fin;
                        end
                        w_push.n = w_push.n + 2'd1;
                    end
                end
            end else if (!r_st.halted) begin
                if ((r_st.swallow_lf && i_char_code == CH_NL) ||
                    (r_st.swallow_cr && i_char_code == CH_CR)) begin
                    // second half of CRLF / LFCR
                    n_st.swallow_lf = 1'b0;
                    n_st.swallow_cr = 1'b0;
                end else begin
                    w_st2.swallow_lf = (i_char_code == CH_CR);
                    w_st2.swallow_cr = (i_char_code == CH_NL);
                    if (i_char_code == CH_CR) begin
                        w_c = CH_NL;
                    end
                    if (!w_st2.held_valid) begin
                        w_st2.held_char  = w_c;
                        w_st2.held_valid = 1'b1;
                        n_st             = w_st2;
                    end else begin
                        w_hr = handle(w_st2, 1'b1, w_c);
                        n_st = w_hr.st;
                        if (w_hr.made) begin
                            w_push.r0 = w_hr.res;
                            w_push.n  = 2'd1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= st_reset();
        end else begin
            r_st <= n_st;
        end
    end

    assign o_push = w_push;

endmodule

// File: rtl/core/mtp_out_fifo.sv
// -----------------------------------------------------------------------------
// Music text preprocessor result queue
// Three-word register queue taking up to two results per cycle, one out.
// -----------------------------------------------------------------------------
module mtp_out_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mtp_pkg::t_push                i_push,
    input  logic                          i_ready,
    output logic                          o_valid,
    output mtp_pkg::t_result              o_head,
    output logic [mtp_pkg::MTP_LVL_W-1:0] o_level
);
    import mtp_pkg::*;

    function automatic logic [MTP_PTR_W-1:0] inc(logic [MTP_PTR_W-1:0] p);
        return (p == MTP_PTR_W'(MTP_FIFO_DEPTH - 1)) ? '0 : p + MTP_PTR_W'(1);
    endfunction

    t_result              r_mem [MTP_FIFO_DEPTH];
    logic [MTP_PTR_W-1:0] r_wr;
    logic [MTP_PTR_W-1:0] r_rd;
    logic [MTP_LVL_W-1:0] r_level;
    logic [MTP_PTR_W-1:0] n_wr;
    logic [MTP_PTR_W-1:0] n_rd;
    logic [MTP_LVL_W-1:0] n_level;
    logic                 w_pop;

    assign w_pop = (r_level != '0) && i_ready;

    always_comb begin
        n_rd    = w_pop ? inc(r_rd) : r_rd;
        n_wr    = r_wr;
        n_level = r_level + MTP_LVL_W'(i_push.n) - MTP_LVL_W'(w_pop);
        unique case (i_push.n)
            2'd0: n_wr = r_wr;
            2'd1: n_wr = inc(r_wr);
            2'd2: n_wr = inc(inc(r_wr));
            default: n_wr = r_wr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[inc(r_wr)] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_level <= n_level;
        end
    end

    assign o_valid = (r_level != '0);
    assign o_head  = r_mem[r_rd];
    assign o_level = r_level;

endmodule

// File: rtl/core/music_text_preprocessor.sv
// -----------------------------------------------------------------------------
// Music text preprocessor
// Cleans a music-macro character stream into characters, newlines and errors.
// -----------------------------------------------------------------------------
// One source character is taken per clock. Its results are computed in the
// same cycle from the held lookahead character and the comment, newline and
// nesting state, and are registered into a three-word result queue whose
// head drives the output channel. Input is taken whenever the queue holds at
// most one word, so with a steady sink the rate is one character per cycle.
// An end-of-text word can yield two results (flushed character plus end or
// error), which is what the queue depth covers.
`include "music_text_preprocessor_macros.svh"

module music_text_preprocessor #(
    parameter int unsigned     NEST_MAX = mtp_pkg::MTP_NEST_MAX,
    parameter longint unsigned LINE_MAX = mtp_pkg::MTP_LINE_MAX
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mtp_in_if.sink    i_in,
    mtp_out_if.source o_out
);
    import mtp_pkg::*;

    logic                 w_accept;
    t_push                w_push;
    t_result              w_head;
    logic                 w_valid;
    logic [MTP_LVL_W-1:0] w_level;

    assign i_in.ready = (w_level <= MTP_LVL_W'(MTP_ACCEPT_LEVEL));
    assign w_accept   = i_in.valid && i_in.ready;

    mtp_core #(
        .NEST_MAX (NEST_MAX),
        .LINE_MAX (LINE_MAX)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_char_code (i_in.char_code),
        .i_is_end    (i_in.is_end),
        .o_push      (w_push)
    );

    mtp_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_ready (o_out.ready),
        .o_valid (w_valid),
        .o_head  (w_head),
        .o_level (w_level)
    );

    assign o_out.valid       = w_valid;
    assign o_out.kind        = w_head.kind;
    assign o_out.out_char    = w_head.out_char;
    assign o_out.line_number = w_head.line_number;
    assign o_out.error_code  = w_head.error_code;
    assign o_out.last        = w_head.last;

    // a double push only ever lands in a queue with two free words
    `MTP_ASSERT_NOW(a_push_room, w_push.n == 2'd2,
        w_level <= MTP_LVL_W'(MTP_ACCEPT_LEVEL), "result queue overflow")
    // errors always close the text, characters never do
    `MTP_ASSERT_NOW(a_err_last, w_valid && w_head.kind == KIND_ERR,
        w_head.last && w_head.error_code != ERR_NONE, "error word not final")
    `MTP_ASSERT_NOW(a_char_not_last, w_valid && w_head.kind == KIND_CHAR,
        !w_head.last && w_head.error_code == ERR_NONE, "char word marked final")
    // nothing is pushed without an accepted input word
    `MTP_ASSERT_NEXT(a_push_needs_accept, !w_accept && w_valid && !o_out.ready,
        $stable(w_level), "queue level moved without traffic")

endmodule

// File: tb/sv/mtp_stream_checker.sv
// -----------------------------------------------------------------------------
// Music text preprocessor stream checker
// Watches the character and result channels, predicts the cleaned stream from
// every accepted source word, and compares each result word field by field.
// -----------------------------------------------------------------------------
module mtp_stream_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    mtp_in_if    i_chars,
    mtp_out_if   i_results,
    output int   o_mismatches,
    output int   o_awaiting,
    output int   o_char_count,
    output int   o_newline_count,
    output int   o_end_count,
    output int   o_error_count
);
    import mtp_pkg::*;

    t_result awaited[$];

    // cleaner state
    logic [MTP_CHAR_W-1:0] held_ch;
    bit                    held_ok;
    bit                    line_cmt;
    bit                    block_cmt;
    bit                    eat_lf;
    bit                    eat_cr;
    int unsigned           brk_depth;
    int unsigned           par_depth;
    longint unsigned       line_no;
    bit                    stopped;

    function automatic void clear_text_state();
        held_ch   = '0;
        held_ok   = 1'b0;
        line_cmt  = 1'b0;
        block_cmt = 1'b0;
        eat_lf    = 1'b0;
        eat_cr    = 1'b0;
        brk_depth = 0;
        par_depth = 0;
        line_no   = 1;
        stopped   = 1'b0;
    endfunction

    function automatic void queue_result(t_kind k, logic [MTP_CHAR_W-1:0] ch,
                                         logic [MTP_LINE_W-1:0] ln, t_err code, logic fin);
        t_result r;
        r.kind        = k;
        r.out_char    = ch;
        r.line_number = ln;
        r.error_code  = code;
        r.last        = fin;
        awaited = {awaited, r};
    endfunction

    function automatic void report_error(t_err code);
        stopped = 1'b1;
        held_ok = 1'b0;
        queue_result(KIND_ERR, '0, line_no[MTP_LINE_W-1:0], code, 1'b1);
    endfunction

    // Resolve the held character, with c as lookahead when has_next is set.
    function automatic void settle_held(bit has_next, logic [MTP_CHAR_W-1:0] c);
        logic [MTP_CHAR_W-1:0] h;
        bit                    paired;
        h      = held_ch;
        paired = 1'b0;
        if (h == CH_NL) begin
            line_cmt = 1'b0;
            if (line_no < MTP_LINE_MAX) line_no++;
            queue_result(KIND_CHAR, CH_NL, line_no[MTP_LINE_W-1:0], ERR_NONE, 1'b0);
        end else if (has_next && h == CH_SLASH && c == CH_SLASH) begin
            // opens a line comment even inside a block comment
            line_cmt = 1'b1;
            paired   = 1'b1;
        end else if (!line_cmt && has_next && h == CH_STAR && c == CH_SLASH) begin
            paired = 1'b1;
            if (!block_cmt) begin
                report_error(ERR_STRAY_CMT);
                return;
            end
            block_cmt = 1'b0;
        end else if (!line_cmt && has_next && h == CH_SLASH && c == CH_STAR) begin
            paired    = 1'b1;
            block_cmt = 1'b1;
        end else if (block_cmt || line_cmt) begin
            // commented out
        end else if (h == CH_SPACE || h == CH_TAB) begin
            // whitespace dropped
        end else if (has_next && h == CH_EM_HI && c == CH_EM_LO) begin
            paired = 1'b1;
        end else begin
            if (h == CH_LBRK && brk_depth < MTP_NEST_MAX) brk_depth++;
            if (h == CH_RBRK) begin
                if (brk_depth == 0) begin
                    report_error(ERR_STRAY_BRK);
                    return;
                end
                brk_depth--;
            end
            if (h == CH_LPAR && par_depth < MTP_NEST_MAX) par_depth++;
            if (h == CH_RPAR) begin
                if (par_depth == 0) begin
                    report_error(ERR_STRAY_PAR);
                    return;
                end
                par_depth--;
            end
            if (h >= CH_UPR_A && h <= CH_UPR_Z) h = h | CH_SPACE;
            queue_result(KIND_CHAR, h, '0, ERR_NONE, 1'b0);
        end
        if (has_next && !paired) begin
            held_ch = c;
            held_ok = 1'b1;
        end else begin
            held_ok = 1'b0;
        end
    endfunction

    function automatic void preprocess_word(logic [MTP_CHAR_W-1:0] code, logic fin);
        logic [MTP_CHAR_W-1:0] c;
        c = code;
        if (fin) begin
            if (stopped) begin
                clear_text_state();
                return;
            end
            if (held_ok) settle_held(1'b0, '0);
            if (!stopped) begin
                if (brk_depth != 0)      report_error(ERR_OPEN_BRK);
                else if (par_depth != 0) report_error(ERR_OPEN_PAR);
                else queue_result(KIND_END, '0, '0, ERR_NONE, 1'b1);
            end
            clear_text_state();
            return;
        end
        if (stopped) return;
        // CR LF / LF CR collapse into one newline
        if ((eat_lf && c == CH_NL) || (eat_cr && c == CH_CR)) begin
            eat_lf = 1'b0;
            eat_cr = 1'b0;
            return;
        end
        eat_lf = (c == CH_CR);
        eat_cr = (c == CH_NL);
        if (c == CH_CR) c = CH_NL;
        if (!held_ok) begin
            held_ch = c;
            held_ok = 1'b1;
            return;
        end
        settle_held(1'b1, c);
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_text_state();
            awaited.delete();
        end else begin
            // results first: a word never answers the source word of the same edge
            if (i_results.valid && i_results.ready) begin
                if (awaited.size() == 0) begin
                    if (o_mismatches < 10)
                        $display({"[%0t] unexpected result word: ",
                                  "kind=%0d char=%h line=%0d err=%0d last=%0b"},
                                 $time, i_results.kind, i_results.out_char,
                                 i_results.line_number, i_results.error_code, i_results.last);
                    o_mismatches++;
                end else begin
                    want = awaited.pop_front();
                    if (i_results.kind !== want.kind || i_results.out_char !== want.out_char ||
                        i_results.line_number !== want.line_number ||
                        i_results.error_code !== want.error_code ||
                        i_results.last !== want.last) begin
                        if (o_mismatches < 10) begin
                            $display("[%0t] result mismatch", $time);
                            $display("    expected kind=%0d char=%h line=%0d err=%0d last=%0b",
                                     want.kind, want.out_char, want.line_number,
                                     want.error_code, want.last);
                            $display("    actual   kind=%0d char=%h line=%0d err=%0d last=%0b",
                                     i_results.kind, i_results.out_char, i_results.line_number,
                                     i_results.error_code, i_results.last);
                        end
                        o_mismatches++;
                    end
                    case (want.kind)
                        KIND_CHAR: begin
                            if (want.out_char == CH_NL) o_newline_count++;
                            else                        o_char_count++;
                        end
                        KIND_END: o_end_count++;
                        default:  o_error_count++;
                    endcase
                end
            end
            if (i_chars.valid && i_chars.ready)
                preprocess_word(i_chars.char_code, i_chars.is_end);
        end
        o_awaiting = awaited.size();
    end

endmodule

// File: tb/sv/tb.sv
// -----------------------------------------------------------------------------
// Music text preprocessor testbench
// Feeds directed and random source texts with random gaps on both channels,
// a long sink hold-off and drain pauses; the checker scores every result word.
// -----------------------------------------------------------------------------
module tb;
    import mtp_pkg::*;

    localparam int WORD_GOAL   = 1150;
    localparam int IDLE_LIMIT  = 2000;
    localparam int LONG_HOLD   = 200;
    localparam int TAIL_CYCLES = 20;

    logic clk;
    logic rst_n;

    mtp_in_if  char_ch ();
    mtp_out_if res_ch ();

    int mismatches;
    int awaiting;
    int char_count;
    int newline_count;
    int end_count;
    int error_count;

    int                    words_sent;
    int                    texts_sent;
    int                    idle_cycles;
    bit                    steady;
    bit                    hold_req;
    logic [MTP_CHAR_W-1:0] text[$];

    music_text_preprocessor dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (char_ch),
        .o_out   (res_ch)
    );

    mtp_stream_checker chk (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_chars         (char_ch),
        .i_results       (res_ch),
        .o_mismatches    (mismatches),
        .o_awaiting      (awaiting),
        .o_char_count    (char_count),
        .o_newline_count (newline_count),
        .o_end_count     (end_count),
        .o_error_count   (error_count)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [MTP_CHAR_W-1:0] rand_char(int unsigned lo, int unsigned hi);
        return MTP_CHAR_W'($urandom_range(lo, hi));
    endfunction

    function automatic void add_char(logic [MTP_CHAR_W-1:0] ch);
        text = {text, ch};
    endfunction

    function automatic logic [MTP_CHAR_W-1:0] plain_char();
        case ($urandom_range(0, 3))
            0:       return 16'h0061 + rand_char(0, 25);
            1:       return CH_UPR_A + rand_char(0, 25);
            2:       return 16'h0030 + rand_char(0, 9);
            default: return 16'h003C + rand_char(0, 2);
        endcase
    endfunction

    function automatic logic [MTP_CHAR_W-1:0] comment_char();
        case ($urandom_range(0, 19))
            0:       return CH_STAR;
            1:       return CH_SLASH;
            2, 3:    return CH_SPACE;
            default: return plain_char();
        endcase
    endfunction

    task automatic add_newline();
        case ($urandom_range(0, 4))
            0: add_char(CH_CR);
            1: add_char(CH_NL);
            2: begin
                add_char(CH_CR);
                add_char(CH_NL);
            end
            3: begin
                add_char(CH_NL);
                add_char(CH_CR);
            end
            default: begin
                add_char(CH_CR);
                add_char(CH_CR);
            end
        endcase
    endtask

    // Mostly well-formed text: nested brackets, comments, newlines, with some noise.
    task automatic build_random_text();
        int                    goal;
        int                    r;
        logic [MTP_CHAR_W-1:0] closers[$];
        text.delete();
        goal = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90) : $urandom_range(3, 30);
        while (text.size() < goal) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                add_char(plain_char());
            end else if (r < 47) begin
                add_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            end else if (r < 50) begin
                add_char(CH_EM_HI);
                add_char(CH_EM_LO);
            end else if (r < 57) begin
                add_newline();
            end else if (r < 61) begin
                add_char(CH_SLASH);
                add_char(CH_SLASH);
                repeat ($urandom_range(0, 6)) add_char(comment_char());
                add_newline();
            end else if (r < 65) begin
                add_char(CH_SLASH);
                add_char(CH_STAR);
                repeat ($urandom_range(0, 6)) begin
                    if ($urandom_range(0, 5) == 0) add_newline();
                    else add_char(comment_char());
                end
                add_char(CH_STAR);
                add_char(CH_SLASH);
            end else if (r < 73) begin
                if ($urandom_range(0, 1)) begin
                    add_char(CH_LBRK);
                    closers = {closers, CH_RBRK};
                end else begin
                    add_char(CH_LPAR);
                    closers = {closers, CH_RPAR};
                end
            end else if (r < 81) begin
                if (closers.size() > 0) add_char(closers.pop_back());
                else add_char(plain_char());
            end else if (r < 85) begin
                add_char(rand_char(0, 65535));
            end else if (r < 87) begin
                add_char($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
            end else if (r < 92) begin
                case ($urandom_range(0, 3))
                    0:       add_char(CH_STAR);
                    1:       add_char(CH_SLASH);
                    2:       add_char(CH_EM_HI);
                    default: add_char(CH_EM_LO);
                endcase
            end else if (r < 94) begin
                // broken input: stray comment close or closer
                case ($urandom_range(0, 2))
                    0: begin
                        add_char(CH_STAR);
                        add_char(CH_SLASH);
                    end
                    1:       add_char(CH_RBRK);
                    default: add_char(CH_RPAR);
                endcase
            end else begin
                add_char(plain_char());
            end
        end
        if ($urandom_range(0, 9) != 0)
            while (closers.size() > 0) add_char(closers.pop_back());
    endtask

    // valid stays high across back-to-back words; lowered only for a gap
    task automatic send_word(input logic [MTP_CHAR_W-1:0] code, input logic fin);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            char_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        char_ch.valid     <= 1'b1;
        char_ch.char_code <= code;
        char_ch.is_end    <= fin;
        do @(posedge clk); while (!(char_ch.valid && char_ch.ready));
        @(negedge clk);
        words_sent++;
    endtask

    task automatic send_text();
        foreach (text[i]) send_word(text[i], 1'b0);
        send_word(rand_char(0, 65535), 1'b1);
        texts_sent++;
    endtask

    task automatic drain();
        char_ch.valid <= 1'b0;
        do @(negedge clk); while (awaiting != 0);
    endtask

    // sink side: random stalls, plus the long hold-off on request
    initial begin
        int stall_left;
        stall_left   = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && !steady && $urandom_range(0, 4) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (char_ch.valid && char_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles", IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [MTP_CHAR_W-1:0] opener;
        logic [MTP_CHAR_W-1:0] closer;
        rst_n             = 1'b0;
        char_ch.valid     = 1'b0;
        char_ch.char_code = '0;
        char_ch.is_end    = 1'b0;
        steady            = 1'b0;
        hold_req          = 1'b0;
        words_sent        = 0;
        texts_sent        = 0;
        idle_cycles       = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // case folding, all newline pairings, whitespace, comment markers in a line comment
        text = '{CH_UPR_Z, CH_CR, CH_NL, CH_UPR_A, CH_NL, CH_CR, CH_CR, CH_SPACE, CH_TAB,
                 CH_EM_HI, CH_EM_LO, CH_SLASH, CH_SLASH, CH_STAR, CH_SLASH, CH_NL};
        send_text();
        // // inside a block comment, block open across a newline, zero and all-ones,
        // flushed opener at end leaves a paren open
        text = '{CH_LBRK, CH_SLASH, CH_STAR, CH_SLASH, CH_SLASH, CH_NL, CH_STAR, CH_SLASH,
                 16'h0000, 16'hFFFF, CH_RBRK, CH_LPAR};
        send_text();
        // stray comment close, then input ignored until end
        text = '{CH_STAR, CH_SLASH, CH_UPR_A};
        send_text();
        text = '{CH_RPAR};
        send_text();
        drain();

        // nesting saturation: one closer more than the counter can hold
        opener = $urandom_range(0, 1) ? CH_LBRK : CH_LPAR;
        closer = (opener == CH_LBRK) ? CH_RBRK : CH_RPAR;
        text.delete();
        repeat (MTP_NEST_MAX + 2) add_char(opener);
        repeat (MTP_NEST_MAX + 1) add_char(closer);
        send_text();

        while (words_sent < WORD_GOAL) begin
            steady = ($urandom_range(0, 5) == 0);
            build_random_text();
            if (texts_sent == 8 || $urandom_range(0, 39) == 0) hold_req = 1'b1;
            send_text();
            if ($urandom_range(0, 7) == 0) drain();
        end
        steady = 1'b0;

        char_ch.valid <= 1'b0;
        do @(negedge clk); while (awaiting != 0);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Fed %0d source words in %0d texts (directed, nesting overflow, random).",
                 words_sent, texts_sent);
        $display({"Checked %0d characters, %0d newlines, %0d clean ends, ",
                  "%0d errors; %0d mismatches."},
                 char_count, newline_count, end_count, error_count, mismatches);
        if (awaiting != 0) $display("%0d expected result words never arrived", awaiting);
        if (mismatches == 0 && awaiting == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
